// ----- design/wrmi_pkg.sv -----
package wrmi_pkg;

   localparam int HALF_WINDOW_DEF = 30;
   localparam int MAX_SAMPLES_DEF = 4096;

   localparam int ADC_W    = 12;
   localparam int PED_W    = 16;
   localparam int THR_W    = 16;
   localparam int SAMPLE_W = 18;
   localparam int VALUE_W  = 32;
   localparam int SINCE_W  = 7;
   localparam int REACH_W  = 8;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ROI_THRESHOLD_ADDR = 2'd0;
   localparam logic [THR_W-1:0]      ROI_THRESHOLD_RST  = 16'd144;
   localparam logic [SINCE_W-1:0]    SINCE_SAT          = 7'd127;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // word handed from the emit stage to the accumulator
   typedef struct packed {
      sample_type value;
      logic       region;
      logic       induction;
      logic       last;
   } emit_word_type;

endpackage

// ----- design/wrmi_cell.sv -----
module wrmi_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  logic                 load,
   input  wrmi_pkg::sample_type load_data,
   input  wrmi_pkg::sample_type next_data,
   output wrmi_pkg::sample_type data
);
   import wrmi_pkg::*;

   sample_type data_ff;
   sample_type data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- design/wrmi_accum.sv -----
module wrmi_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            word_valid,
   input  wrmi_pkg::emit_word_type         word,
   input  logic                            rsp_stall,
   output logic                            out_ready,
   output logic                            rsp_valid,
   output logic signed [wrmi_pkg::VALUE_W-1:0] rsp_wire_value,
   output logic                            rsp_last_result
);
   import wrmi_pkg::*;

   logic signed [VALUE_W-1:0] sum_ff;
   logic signed [VALUE_W-1:0] sum_in;
   logic                      valid_ff;
   logic                      valid_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      last_ff;
   logic                      last_in;

   logic                      load;
   logic signed [VALUE_W:0]   wide_sum;
   logic signed [VALUE_W-1:0] sat_sum;
   logic signed [VALUE_W-1:0] upd_sum;
   logic signed [VALUE_W-1:0] ext_value;

   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = word_valid && out_ready;

   always_comb begin
      ext_value = VALUE_W'(word.value);
      wide_sum  = {sum_ff[VALUE_W-1], sum_ff} + {{(VALUE_W-SAMPLE_W+1){word.value[SAMPLE_W-1]}},
                                                 word.value};
      if (wide_sum[VALUE_W] != wide_sum[VALUE_W-1]) begin
         sat_sum = wide_sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                     : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         sat_sum = wide_sum[VALUE_W-1:0];
      end
      upd_sum = word.region ? sat_sum : sum_ff;

      sum_in   = sum_ff;
      value_in = value_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         last_in  = word.last;
         sum_in   = word.last ? '0 : upd_sum;
         if (word.induction) begin
            value_in = word.region ? upd_sum : '0;
         end else begin
            value_in = ext_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sum_ff   <= sum_in;
      end
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_wire_value  = value_ff;
   assign rsp_last_result = last_ff;

endmodule

// ----- design/wire_roi_mask_integrator_core.sv -----
// Wire ROI mask and integrator. Takes one waveform sample per cycle unless
// stalled, subtracts the pedestal (4 fraction bits) and, on induction wires,
// outputs the running sum over a region of interest of HALF_WINDOW-1 samples
// either side of every sample above roi_threshold (zero outside it);
// collection wires pass the pedestal-subtracted sample. Samples wait in a row
// of HALF_WINDOW cells, so each result leaves HALF_WINDOW-1 samples after its
// input; a result word passes the emit and accumulator registers before rsp.
// Within a wire one sample is taken every cycle unless rsp_stall holds the
// emit stage. A wire's last sample releases up to HALF_WINDOW words one per
// cycle while the emit stage is free; req_stall stays high until all are out.
module wire_roi_mask_integrator_core #(
   parameter int HALF_WINDOW = wrmi_pkg::HALF_WINDOW_DEF,
   parameter int MAX_SAMPLES = wrmi_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wrmi_pkg::ADC_W-1:0]           req_adc_sample,
   input  logic [wrmi_pkg::PED_W-1:0]           req_pedestal,
   input  logic                                 req_is_induction,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wrmi_pkg::VALUE_W-1:0]  rsp_wire_value,
   output logic                                 rsp_last_result,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wrmi_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wrmi_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wrmi_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import wrmi_pkg::*;

   localparam int DELAY = HALF_WINDOW - 1;
   localparam int FW    = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
   localparam int EW    = $clog2(MAX_SAMPLES + 1);

   logic [THR_W-1:0]   thr_ff;
   logic [THR_W-1:0]   thr_in;
   logic [FW-1:0]      fill_ff;
   logic [FW-1:0]      fill_in;
   logic [FW-1:0]      remain_ff;
   logic [FW-1:0]      remain_in;
   logic               flush_ff;
   logic               flush_in;
   logic [SINCE_W-1:0] since_ff;
   logic [SINCE_W-1:0] since_in;
   logic [EW-1:0]      emitted_ff;
   logic [EW-1:0]      emitted_in;
   logic               ind_ff;
   logic               ind_in;
   logic               a_valid_ff;
   logic               a_valid_in;
   emit_word_type      a_word_ff;
   emit_word_type      a_word_in;

   sample_type         sample_s;
   sample_type         head;
   sample_type         cell_q [HALF_WINDOW];
   logic               hit;
   logic [SINCE_W-1:0] since_upd;
   logic [SINCE_W-1:0] since_sel;
   logic               out_ready;
   logic               a_ready;
   logic               accept;
   logic               full;
   logic               emit_acc;
   logic               emit_fl;
   logic               shift;
   logic               wr_en;
   logic [FW-1:0]      wr_idx;
   logic [FW-1:0]      behind;
   logic               last_sel;
   logic               region;
   logic               wire_end;
   logic               csr_wr;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == ROI_THRESHOLD_ADDR);
   assign thr_in     = csr_wr ? csr_pwdata[THR_W-1:0] : thr_ff;
   assign csr_prdata = (csr_paddr == ROI_THRESHOLD_ADDR) ? CSR_DATA_W'(thr_ff) : '0;

   // front end
   assign sample_s  = $signed({2'b00, req_adc_sample, 4'b0000}) - $signed({2'b00, req_pedestal});
   assign hit       = sample_s > $signed({2'b00, thr_ff});
   assign since_upd = hit ? '0 : ((since_ff == SINCE_SAT) ? since_ff : since_ff + 1'b1);

   assign a_ready   = !a_valid_ff || out_ready;
   assign req_stall = flush_ff || !a_ready;
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == FW'(DELAY));
   assign emit_acc  = accept && (req_last_sample || full);
   assign emit_fl   = flush_ff && a_ready;
   assign shift     = emit_acc || emit_fl;

   assign wr_en  = accept && !(emit_acc && (fill_ff == '0));
   assign wr_idx = emit_acc ? fill_ff - 1'b1 : fill_ff;

   // delay row
   for (genvar i = 0; i < HALF_WINDOW; i++) begin : g_cell
      sample_type next_data;
      if (i == HALF_WINDOW - 1) begin : g_end
         assign next_data = '0;
      end else begin : g_mid
         assign next_data = cell_q[i+1];
      end
      wrmi_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .load      (wr_en && (wr_idx == FW'(i))),
         .load_data (sample_s),
         .next_data (next_data),
         .data      (cell_q[i])
      );
   end

   // emit selection
   always_comb begin
      if (flush_ff) begin
         head      = cell_q[0];
         behind    = remain_ff - 1'b1;
         since_sel = since_ff;
         last_sel  = (remain_ff == FW'(1));
      end else begin
         head      = (fill_ff == '0) ? sample_s : cell_q[0];
         behind    = req_last_sample ? fill_ff : FW'(DELAY);
         since_sel = since_upd;
         last_sel  = req_last_sample && (fill_ff == '0);
      end
      region = (REACH_W'(since_sel) <= REACH_W'(behind) + REACH_W'(DELAY))
               && (emitted_ff < EW'(MAX_SAMPLES));
   end

   assign wire_end = shift && last_sel;

   always_comb begin
      fill_in    = fill_ff;
      remain_in  = remain_ff;
      flush_in   = flush_ff;
      since_in   = since_ff;
      emitted_in = emitted_ff;
      ind_in     = ind_ff;
      if (accept) begin
         since_in = since_upd;
         ind_in   = req_is_induction;
         if (req_last_sample) begin
            fill_in   = '0;
            remain_in = fill_ff;
            flush_in  = (fill_ff != '0);
         end else if (!full) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (emit_fl) begin
         remain_in = remain_ff - 1'b1;
         if (remain_ff == FW'(1)) begin
            flush_in = 1'b0;
         end
      end
      if (shift && (emitted_ff < EW'(MAX_SAMPLES))) begin
         emitted_in = emitted_ff + 1'b1;
      end
      if (wire_end) begin
         since_in   = SINCE_SAT;
         emitted_in = '0;
      end

      a_valid_in = shift || (a_valid_ff && !out_ready);
      a_word_in  = a_word_ff;
      if (shift) begin
         a_word_in.value     = head;
         a_word_in.region    = region;
         a_word_in.induction = flush_ff ? ind_ff : req_is_induction;
         a_word_in.last      = last_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= ROI_THRESHOLD_RST;
         fill_ff    <= '0;
         remain_ff  <= '0;
         flush_ff   <= 1'b0;
         since_ff   <= SINCE_SAT;
         emitted_ff <= '0;
         ind_ff     <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         thr_ff     <= thr_in;
         fill_ff    <= fill_in;
         remain_ff  <= remain_in;
         flush_ff   <= flush_in;
         since_ff   <= since_in;
         emitted_ff <= emitted_in;
         ind_ff     <= ind_in;
         a_valid_ff <= a_valid_in;
      end
      a_word_ff <= a_word_in;
   end

   wrmi_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .word_valid      (a_valid_ff),
      .word            (a_word_ff),
      .rsp_stall       (rsp_stall),
      .out_ready       (out_ready),
      .rsp_valid       (rsp_valid),
      .rsp_wire_value  (rsp_wire_value),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// ----- dv/wire_roi_mask_integrator_core_tb.sv -----
module wire_roi_mask_integrator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wrmi_pkg::*;

   localparam int HALF        = HALF_WINDOW_DEF;
   localparam int SAMPLE_CAP  = MAX_SAMPLES_DEF;
   localparam int PERIOD      = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 2 * HALF + 8;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } roi_word_type;

   // Mirrors the mask/integrate behavior and keeps the words still owed by the block.
   class roi_sum_board;
      logic [THR_W-1:0]          threshold;
      sample_type                held[HALF];
      int unsigned               held_count;
      logic signed [VALUE_W-1:0] wire_sum;
      logic [SINCE_W-1:0]        since_hit;
      int unsigned               out_index;
      roi_word_type              owed[$];
      int                        errors;

      function new();
         threshold = ROI_THRESHOLD_RST;
         errors    = 0;
         clear_wire();
      endfunction

      function void clear_wire();
         foreach (held[i]) held[i] = '0;
         held_count = 0;
         wire_sum   = '0;
         since_hit  = SINCE_SAT;
         out_index  = 0;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void release_sample(sample_type v, int unsigned behind, bit induction,
                                   bit last);
         bit           in_roi;
         longint       sum;
         roi_word_type w;
         in_roi = (since_hit <= behind + HALF - 1) && (out_index < SAMPLE_CAP);
         if (in_roi) begin
            sum = longint'(wire_sum) + longint'(v);
            if (sum > longint'(32'sh7fffffff)) wire_sum = 32'sh7fffffff;
            else if (sum < longint'(32'sh80000000)) wire_sum = 32'sh80000000;
            else wire_sum = sum[VALUE_W-1:0];
         end
         if (induction) w.value = in_roi ? wire_sum : '0;
         else w.value = VALUE_W'(v);
         w.last = last;
         if (out_index < SAMPLE_CAP) out_index++;
         owed.insert(owed.size(), w);
      endfunction

      function void note_word(logic [ADC_W-1:0] adc, logic [PED_W-1:0] ped, bit induction,
                              bit last);
         int          s;
         int unsigned total;
         s = int'(adc) * 16 - int'(ped);
         if (s > int'(threshold)) since_hit = '0;
         else if (since_hit != SINCE_SAT) since_hit++;
         held[held_count] = s[SAMPLE_W-1:0];
         held_count++;
         if (last) begin
            total = held_count;
            for (int unsigned k = 0; k < total; k++)
               release_sample(held[k], total - 1 - k, induction, k == total - 1);
            clear_wire();
         end else if (held_count == HALF) begin
            release_sample(held[0], HALF - 1, induction, 1'b0);
            for (int i = 0; i < HALF - 1; i++) held[i] = held[i+1];
            held[HALF-1] = '0;
            held_count--;
         end
      endfunction

      function void check_word(logic signed [VALUE_W-1:0] value, logic last);
         roi_word_type w;
         if (owed.size() == 0) begin
            report($sformatf("unexpected word: value %0d last %0b", value, last));
            return;
         end
         w = owed.pop_front();
         if (w.value !== value || w.last !== last)
            report($sformatf("word mismatch: expected value %0d last %0b, got value %0d last %0b",
                             w.value, w.last, value, last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic [ADC_W-1:0]          req_adc_sample   = '0;
   logic [PED_W-1:0]          req_pedestal     = '0;
   logic                      req_is_induction = 1'b0;
   logic                      req_last_sample  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic signed [VALUE_W-1:0] rsp_wire_value;
   logic                      rsp_last_result;
   logic                      csr_psel         = 1'b0;
   logic                      csr_penable      = 1'b0;
   logic                      csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr        = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   roi_sum_board board = new();
   int           cycles = 0;
   bit           steady = 1'b0;

   wire_roi_mask_integrator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .req_pedestal     (req_pedestal),
      .req_is_induction (req_is_induction),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_wire_value   (rsp_wire_value),
      .rsp_last_result  (rsp_last_result),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // occasional stretches with no idling on either side
   function automatic int draw_gap();
      if ($urandom_range(0, 39) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(0, 7);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_word(rsp_wire_value, rsp_last_result);
   end

   always begin : rsp_pacer
      int hold;
      hold = draw_gap();
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold) @(posedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
      do @(posedge clock); while (rsp_valid !== 1'b1);
   end

   task automatic send_word(logic [ADC_W-1:0] adc, logic [PED_W-1:0] ped, bit ind, bit last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_adc_sample   <= adc;
      req_pedestal     <= ped;
      req_is_induction <= ind;
      req_last_sample  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_word(adc, ped, ind, last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_threshold(logic [THR_W-1:0] thr);
      logic [CSR_DATA_W-1:0] rd;
      drain();
      csr_write(ROI_THRESHOLD_ADDR, CSR_DATA_W'(thr));
      @(posedge clock);
      csr_read(ROI_THRESHOLD_ADDR, rd);
      if (rd !== CSR_DATA_W'(thr))
         board.report($sformatf("threshold readback: expected %0d, got %0d", thr, rd));
      board.threshold = thr;
   endtask

   // baseline noise of a few counts, or a pulse somewhere above the baseline
   function automatic logic [ADC_W-1:0] pick_adc(logic [ADC_W-1:0] base, bit pulse);
      int a;
      if (pulse) a = int'(base) + int'($urandom_range(0, 4095 - int'(base)));
      else a = int'(base) + int'($urandom_range(0, 6)) - 3;
      if (a < 0) a = 0;
      if (a > 4095) a = 4095;
      return a[ADC_W-1:0];
   endfunction

   task automatic random_wire(int unsigned len);
      logic [ADC_W-1:0] base;
      logic [ADC_W-1:0] adc;
      logic [PED_W-1:0] wire_ped;
      logic [PED_W-1:0] ped;
      bit               wire_ind;
      bit               ind;
      int unsigned      r;
      base     = ADC_W'($urandom_range(0, 4095));
      wire_ped = {base, 4'($urandom_range(0, 15))};
      wire_ind = $urandom_range(0, 3) != 0;
      for (int unsigned i = 0; i < len; i++) begin
         r   = $urandom_range(0, 99);
         ind = ($urandom_range(0, 19) == 0) ? !wire_ind : wire_ind;
         ped = wire_ped;
         if (r < 8) begin
            adc = ADC_W'($urandom);
            ped = PED_W'($urandom);
            ind = 1'($urandom);
         end else begin
            adc = pick_adc(base, r < 20);
         end
         send_word(adc, ped, ind, i == len - 1);
      end
   endtask

   task automatic random_phase(int unsigned items);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 90);
         random_wire(len);
         sent += len;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short induction wire: field extremes, threshold edge, hit in the middle
      send_word(12'd0,    16'd0,     1'b1, 1'b0);
      send_word(12'd4095, 16'd0,     1'b1, 1'b0);
      send_word(12'd9,    16'd0,     1'b1, 1'b0);
      send_word(12'd10,   16'd15,    1'b1, 1'b0);
      send_word(12'd0,    16'd65535, 1'b1, 1'b1);
      // no hits: nothing may carry over from the previous wire
      send_word(12'd9,    16'd0,     1'b1, 1'b0);
      send_word(12'd4095, 16'd65535, 1'b1, 1'b0);
      send_word(12'd0,    16'd0,     1'b1, 1'b1);
      // collection pass-through
      send_word(12'd4095, 16'd0,     1'b0, 1'b0);
      send_word(12'd0,    16'd65535, 1'b0, 1'b1);
      // one-sample wire with a hit
      send_word(12'd4095, 16'd0,     1'b1, 1'b1);
      // mixed modes, flushed as collection
      send_word(12'd500,  16'd8000,  1'b1, 1'b0);
      send_word(12'd600,  16'd8000,  1'b0, 1'b0);
      send_word(12'd500,  16'd8000,  1'b1, 1'b0);
      send_word(12'd2048, 16'd32768, 1'b0, 1'b0);
      send_word(12'd499,  16'd8000,  1'b1, 1'b0);
      send_word(12'd501,  16'd8000,  1'b0, 1'b1);

      program_threshold(16'd0);
      random_phase(80);
      program_threshold(16'hffff);
      random_phase(60);
      program_threshold(16'($urandom_range(16, 400)));
      random_phase(100);
      program_threshold(ROI_THRESHOLD_RST);
      random_phase(60);

      drain();
      if (board.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
design/wrmi_pkg.sv
design/wrmi_cell.sv
design/wrmi_accum.sv
design/wire_roi_mask_integrator_core.sv
dv/wire_roi_mask_integrator_core_tb.sv
